// ===== rtl/fir_lpf_pkg.sv =====
// Shared types and constants for the FIR low-pass filter.
// No dependencies; imported by every module of the filter.
`default_nettype none

package fir_lpf_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int PROD_W      = 2 * SAMPLE_W;
  localparam int FRAC_BITS   = 15;
  localparam int ROUND_HALF  = 1 << (FRAC_BITS - 1);

  // Weight registers and the index port that writes them
  localparam int NUM_WEIGHTS  = 8;
  localparam int WEIGHT_IDX_W = $clog2(NUM_WEIGHTS);
  localparam int CFG_INDEX_W  = 8;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  localparam sample_t SAT_MAX = 16'sh7fff;
  localparam sample_t SAT_MIN = 16'sh8000;

endpackage

`default_nettype wire

// ===== rtl/fir_lpf_cell.sv =====
// One tap cell of the systolic FIR chain: multiply, add to the partial sum, register.
// Depends on fir_lpf_pkg.
`default_nettype none

module fir_lpf_cell #(
  parameter int TAPS  = 8,
  parameter int IDX   = 0,
  parameter int ACC_W = 35
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  logic                    valid_in,
  input  logic signed [ACC_W-1:0] acc_in,
  input  fir_lpf_pkg::sample_t    win_in [TAPS],
  input  fir_lpf_pkg::sample_t    weight,
  output logic                    valid_out,
  output logic signed [ACC_W-1:0] acc_out,
  output fir_lpf_pkg::sample_t    win_out [TAPS]
);
  import fir_lpf_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc_next;

  // Weight times this cell's sample, added to the running sum
  always_comb begin
    prod     = weight * win_in[IDX];
    acc_next = acc_in + ACC_W'(prod);
  end

  // Advance the valid flag with the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (advance) begin
      valid_out <= valid_in;
    end
  end

  // Hand the partial sum and the window on to the next cell
  always_ff @(posedge clk) begin
    if (advance) begin
      acc_out <= acc_next;
      win_out <= win_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fir_lpf_out.sv =====
// Output stage: round the full sum to Q1.15, saturate, and hold the result word.
// Depends on fir_lpf_pkg.
`default_nettype none

module fir_lpf_out #(
  parameter int ACC_W = 35
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    valid_in,
  input  logic signed [ACC_W-1:0] acc_in,
  input  logic                    out_ready,
  output logic                    advance,
  output logic                    out_valid,
  output fir_lpf_pkg::sample_t    filtered_out,
  output logic                    clipped
);
  import fir_lpf_pkg::*;

  localparam int QW = ACC_W + 1 - FRAC_BITS;

  logic [ACC_W:0]  biased;
  logic [QW-1:0]   q;
  logic            over;
  logic            under;
  sample_t         res_next;

  // Add half an LSB, then floor by dropping the fraction bits
  always_comb begin
    biased = {acc_in[ACC_W-1], acc_in} + (ACC_W+1)'(ROUND_HALF);
    q      = biased[ACC_W:FRAC_BITS];
    over   = ~q[QW-1] & (|q[QW-2:SAMPLE_W-1]);
    under  = q[QW-1] & ~(&q[QW-2:SAMPLE_W-1]);
    if (over) begin
      res_next = SAT_MAX;
    end else if (under) begin
      res_next = SAT_MIN;
    end else begin
      res_next = sample_t'(q[SAMPLE_W-1:0]);
    end
  end

  // The chain moves when the output register is empty or being drained
  assign advance = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      filtered_out <= res_next;
      clipped      <= over | under;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fir_low_pass_filter.sv =====
// Top level of the streaming FIR low-pass filter: weights, sample history, cell chain.
// Depends on fir_lpf_pkg, fir_lpf_cell and fir_lpf_out.
//
//   channel | handshake             | payload
//   --------+-----------------------+-------------------------------
//   cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//   in      | in_valid / in_ready   | sample_in
//   out     | out_valid / out_ready | filtered_out, clipped
//
// One sample per clock sustained while the output word is not stalled. From accept to
// output word, the history register loads on the accepting edge, then one registered
// cell per tap and the rounding register follow in turn.
// Synchronous reset clears weights, history and all valid flags.
// The whole chain stalls together while the output word waits; in_ready follows
// that stall, so a new word is taken whenever the output register can move.
// cfg_ready is always high; writes take effect in the next cycle.
`default_nettype none

module fir_low_pass_filter #(
  parameter int TAPS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [fir_lpf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  fir_lpf_pkg::sample_t                  cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  fir_lpf_pkg::sample_t                  sample_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output fir_lpf_pkg::sample_t                  filtered_out,
  output logic                                  clipped
);
  import fir_lpf_pkg::*;

  localparam int ACC_W = PROD_W + $clog2(TAPS);

  sample_t                 tap_weight [NUM_WEIGHTS];
  sample_t                 hist [TAPS];
  logic                    hist_valid;
  logic                    advance;
  logic                    accept;

  logic                    valid_chain [TAPS+1];
  logic signed [ACC_W-1:0] acc_chain   [TAPS+1];
  sample_t                 win_chain   [TAPS][TAPS];

  assign cfg_ready = 1'b1;
  assign in_ready  = advance;
  assign accept    = in_valid & advance;

  // Weight registers; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_weight <= '{default: '0};
    end else if (cfg_valid && cfg_ready && (cfg_index < CFG_INDEX_W'(NUM_WEIGHTS))) begin
      tap_weight[cfg_index[WEIGHT_IDX_W-1:0]] <= cfg_data;
    end
  end

  // Shift the new sample in; after the shift the register holds this word's window
  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '{default: '0};
    end else if (accept) begin
      for (int k = 0; k < TAPS - 1; k++) begin
        hist[k] <= hist[k+1];
      end
      hist[TAPS-1] <= sample_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_valid <= 1'b0;
    end else if (advance) begin
      hist_valid <= in_valid;
    end
  end

  assign valid_chain[0] = hist_valid;
  assign acc_chain[0]   = '0;
  assign win_chain[0]   = hist;

  // One cell per tap, oldest sample first
  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    if (k < TAPS - 1) begin : g_mid
      fir_lpf_cell #(
        .TAPS  (TAPS),
        .IDX   (k),
        .ACC_W (ACC_W)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .advance   (advance),
        .valid_in  (valid_chain[k]),
        .acc_in    (acc_chain[k]),
        .win_in    (win_chain[k]),
        .weight    (tap_weight[k]),
        .valid_out (valid_chain[k+1]),
        .acc_out   (acc_chain[k+1]),
        .win_out   (win_chain[k+1])
      );
    end else begin : g_last
      fir_lpf_cell #(
        .TAPS  (TAPS),
        .IDX   (k),
        .ACC_W (ACC_W)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .advance   (advance),
        .valid_in  (valid_chain[k]),
        .acc_in    (acc_chain[k]),
        .win_in    (win_chain[k]),
        .weight    (tap_weight[k]),
        .valid_out (valid_chain[k+1]),
        .acc_out   (acc_chain[k+1]),
        .win_out   ()
      );
    end
  end

  // Round, saturate and hold the result word
  fir_lpf_out #(
    .ACC_W (ACC_W)
  ) u_out (
    .clk          (clk),
    .rst          (rst),
    .valid_in     (valid_chain[TAPS]),
    .acc_in       (acc_chain[TAPS]),
    .out_ready    (out_ready),
    .advance      (advance),
    .out_valid    (out_valid),
    .filtered_out (filtered_out),
    .clipped      (clipped)
  );

`ifndef ASSERT_OFF
  // A waiting output word must hold off the input side
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while output word stalled");

  // A clipped word carries one of the two rails
  a_clip_at_rail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clipped) |-> ((filtered_out == SAT_MAX) || (filtered_out == SAT_MIN)))
    else $error("clipped word not at a saturation rail");

  // Reset leaves no output word pending
  a_reset_empties: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output word valid after reset");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for fir_low_pass_filter: directed and random sample words, weight sets.
// Depends on fir_lpf_pkg and the filter RTL; holds its own scoreboard class and drive tasks.

module testbench;
  import fir_lpf_pkg::*;

  localparam int TAPS        = 8;
  localparam int LATENCY     = TAPS + 1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_PHASES = 5;
  localparam int PHASE_WORDS = 96;

  // Weight register indexes; anything from IDX_FIRST_UNUSED up is ignored by the block
  localparam int TAP_OLDEST = 0;
  localparam int TAP_NEWEST = NUM_WEIGHTS - 1;
  localparam logic [CFG_INDEX_W-1:0] IDX_FIRST_UNUSED = NUM_WEIGHTS;
  localparam logic [CFG_INDEX_W-1:0] IDX_LAST_UNUSED  = '1;

  // Weight sets used by the random phases
  typedef enum int {
    WSET_FULL,
    WSET_GENTLE,
    WSET_EXTREME,
    WSET_ONE_TAP,
    WSET_MIXED
  } weight_set_e;

  // Filter predictor and queue of expected output words
  class fir_lpf_scoreboard;
    sample_t weight[NUM_WEIGHTS];
    sample_t history[$];
    sample_t want_filtered[$];
    logic    want_clipped[$];
    int      errors;

    function new();
      for (int k = 0; k < NUM_WEIGHTS; k++) weight[k] = '0;
      for (int k = 0; k < TAPS - 1; k++) history.push_back('0);
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, sample_t data);
      if (idx < NUM_WEIGHTS) weight[idx] = data;
    endfunction

    function int pending();
      return want_filtered.size();
    endfunction

    // Weigh the window, round half up, saturate, then shift the sample in
    function void note_sample(sample_t s);
      longint  acc;
      longint  q;
      sample_t tap_in;
      logic    clip;
      acc = 0;
      clip = 1'b0;
      for (int k = 0; k < TAPS; k++) begin
        tap_in = (k == TAPS - 1) ? s : history[k];
        acc += longint'(weight[k]) * longint'(tap_in);
      end
      q = (acc + ROUND_HALF) >>> FRAC_BITS;
      if (q > longint'(SAT_MAX)) begin
        q = longint'(SAT_MAX);
        clip = 1'b1;
      end else if (q < longint'(SAT_MIN)) begin
        q = longint'(SAT_MIN);
        clip = 1'b1;
      end
      want_filtered.push_back(sample_t'(q));
      want_clipped.push_back(clip);
      if (TAPS > 1) begin
        history.push_back(s);
        void'(history.pop_front());
      end
    endfunction

    function void check_result(sample_t got_filtered, logic got_clipped);
      sample_t exp_filtered;
      logic    exp_clipped;
      if (want_filtered.size() == 0) begin
        errors++;
        $display("%0t: unexpected output word, filtered_out %0d clipped %0b",
                 $time, got_filtered, got_clipped);
        return;
      end
      exp_filtered = want_filtered.pop_front();
      exp_clipped  = want_clipped.pop_front();
      if (got_filtered !== exp_filtered) begin
        errors++;
        $display("%0t: filtered_out expected %0d, actual %0d",
                 $time, exp_filtered, got_filtered);
      end
      if (got_clipped !== exp_clipped) begin
        errors++;
        $display("%0t: clipped expected %0b, actual %0b", $time, exp_clipped, got_clipped);
      end
    endfunction
  endclass

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  sample_t                cfg_data  = '0;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  sample_t                sample_in = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  sample_t                filtered_out;
  logic                   clipped;

  fir_lpf_scoreboard filt_model = new();

  // Sender burst state and receiver stall pattern
  int          burst_left = 0;
  logic        gaps_on    = 1'b0;
  logic        rx_always  = 1'b1;
  logic [12:0] rx_pattern = 13'h1;
  int          rx_pos     = 0;
  int          cycles     = 0;

  fir_low_pass_filter #(
    .TAPS(TAPS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample_in   (sample_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .filtered_out(filtered_out),
    .clipped     (clipped)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stall the output on a rotating pattern unless told to stay ready
  always @(negedge clk) begin
    rx_pos    <= (rx_pos == 12) ? 0 : rx_pos + 1;
    out_ready <= rx_always | rx_pattern[rx_pos];
  end

  // Count cycles, check every accepted output word
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[fir_low_pass_filter] ERROR");
      $finish;
    end else if (!rst && out_valid && out_ready) begin
      filt_model.check_result(filtered_out, clipped);
    end
  end

  // Offer one register write and hold it until taken; the caller drops cfg_valid
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, sample_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    filt_model.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic load_weights(sample_t w[NUM_WEIGHTS]);
    for (int k = 0; k < NUM_WEIGHTS; k++) write_reg(k, w[k]);
  endtask

  // Offer one sample word, inserting a random gap at the start of each burst when gaps are on
  task automatic send_sample(sample_t s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gaps_on) begin
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    sample_in <= s;
    do @(posedge clk); while (!in_ready);
    filt_model.note_sample(s);
    @(negedge clk);
  endtask

  // Drop valid, wait for every expected word, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (filt_model.pending() > 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  initial begin
    sample_t w[NUM_WEIGHTS];
    sample_t s;
    weight_set_e wset;

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset weights are zero: every word filters to zero
    send_sample(SAT_MAX);
    send_sample(SAT_MIN);
    send_sample('0);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    settle();

    // Newest tap only, near unity; writes to unused indexes must change nothing
    for (int k = 0; k < NUM_WEIGHTS; k++) w[k] = '0;
    w[TAP_NEWEST] = SAT_MAX;
    load_weights(w);
    write_reg(IDX_FIRST_UNUSED, SAT_MIN);
    write_reg(IDX_LAST_UNUSED, 16'sh5a5a);
    cfg_valid <= 1'b0;
    send_sample(SAT_MAX);
    send_sample(SAT_MIN);
    send_sample(16'sd1);
    settle();

    // Exact half LSB products: round towards plus infinity
    w[TAP_NEWEST] = 16'sd1;
    load_weights(w);
    cfg_valid <= 1'b0;
    send_sample(16'sd16384);
    send_sample(-16'sd16384);
    send_sample(-16'sd16385);
    settle();

    // Full-scale negative weights: clip high, then pass through mid-range
    for (int k = 0; k < NUM_WEIGHTS; k++) w[k] = SAT_MIN;
    load_weights(w);
    cfg_valid <= 1'b0;
    send_sample(SAT_MIN);
    send_sample(SAT_MIN);
    repeat (4) send_sample(SAT_MAX);
    settle();

    // Random phases, each with its own weight set; idling and output stalls in all but the first
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wset = weight_set_e'(ph);
      gaps_on    = (ph != 0);
      rx_always  <= (ph == 0);
      rx_pattern <= 13'($urandom) | 13'h1;
      for (int k = 0; k < NUM_WEIGHTS; k++) begin
        case (wset)
          WSET_GENTLE:  w[k] = sample_t'($urandom_range(0, 8191) - 4096);
          WSET_EXTREME: begin
            case ($urandom_range(0, 2))
              0:       w[k] = SAT_MIN;
              1:       w[k] = SAT_MAX;
              default: w[k] = '0;
            endcase
          end
          WSET_ONE_TAP: w[k] = '0;
          default:      w[k] = sample_t'($urandom);
        endcase
      end
      if (wset == WSET_ONE_TAP) w[$urandom_range(TAP_OLDEST, TAP_NEWEST)] = sample_t'($urandom);
      load_weights(w);
      if ($urandom_range(0, 1))
        write_reg($urandom_range(IDX_FIRST_UNUSED, IDX_LAST_UNUSED), sample_t'($urandom));
      cfg_valid <= 1'b0;

      // Mix full-scale, small and arbitrary sample words
      for (int i = 0; i < PHASE_WORDS; i++) begin
        case ($urandom_range(0, 3))
          0:       s = $urandom_range(0, 1) ? SAT_MAX : SAT_MIN;
          1:       s = sample_t'($urandom_range(0, 63) - 32);
          default: s = sample_t'($urandom);
        endcase
        send_sample(s);
      end
      settle();
    end

    if (filt_model.errors == 0) begin
      $display("[fir_low_pass_filter] OK");
    end else begin
      $display("[fir_low_pass_filter] ERROR");
    end
    $finish;
  end

endmodule
